@@ hdl/rme_pkg.sv @@
package rme_pkg;

  localparam int DataWidth = 24;
  localparam int CordicStages = 20;
  localparam int SumWidth = 2 * DataWidth + 1;
  localparam int SqrtWidth = DataWidth + 1;
  localparam int SqrtSteps = SqrtWidth;
  localparam int CordWidth = DataWidth + 8 + 3;
  localparam int AngWidth = 34;
  localparam int OutWidth = 23;
  localparam int ThrWidth = 23;
  localparam logic [ThrWidth-1:0] ThrReset = 23'd4;
  localparam logic signed [AngWidth-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [OutWidth-1:0] AngleLimit = 23'sd3294199;

  localparam logic [31:0] AtanTab [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  // one CORDIC lane
  typedef struct packed {
    logic                        zero;
    logic signed [CordWidth-1:0] x;
    logic signed [CordWidth-1:0] y;
    logic signed [AngWidth-1:0]  ang;
  } cord_t;

  // matrix elements still waiting for the sqrt result
  typedef struct packed {
    logic signed [DataWidth-1:0] m00;
    logic signed [DataWidth-1:0] m10;
    logic signed [DataWidth-1:0] m20;
    logic signed [DataWidth-1:0] m21;
    logic signed [DataWidth-1:0] m22;
    logic signed [DataWidth-1:0] m12;
    logic signed [DataWidth-1:0] m11;
  } mat_t;

  typedef struct packed {
    logic [SumWidth-1:0]  rem;
    logic [SqrtWidth-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic sing;
    cord_t cx;
    cord_t cy;
    cord_t cz;
  } lanes_t;

  function automatic cord_t cord_init(logic signed [DataWidth-1:0] y,
                                      logic signed [DataWidth:0] x);
    cord_t r;
    logic signed [CordWidth-1:0] xs;
    logic signed [CordWidth-1:0] ys;
    xs = CordWidth'(x) <<< 8;
    ys = CordWidth'(y) <<< 8;
    r.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      r.ang = (y >= 0) ? PiQ30 : -PiQ30;
      r.x = -xs;
      r.y = -ys;
    end else begin
      r.ang = '0;
      r.x = xs;
      r.y = ys;
    end
    return r;
  endfunction

  function automatic logic signed [OutWidth-1:0] ang_out(cord_t c);
    logic signed [AngWidth-1:0] q;
    q = (c.ang + AngWidth'(512)) >>> 10;
    if (c.zero) return '0;
    if (q > AngWidth'(AngleLimit)) return AngleLimit;
    if (q < -AngWidth'(AngleLimit)) return -AngleLimit;
    return q[OutWidth-1:0];
  endfunction

endpackage

@@ hdl/rme_sqrt_cell.sv @@
module rme_sqrt_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [$clog2(rme_pkg::SqrtSteps)-1:0] step_i,
  input  logic                                 vld_i,
  input  rme_pkg::sqrt_t                       s_i,
  input  rme_pkg::mat_t                        m_i,
  output logic                                 vld_o,
  output rme_pkg::sqrt_t                       s_o,
  output rme_pkg::mat_t                        m_o
);
  // one restoring digit step: bit position = SqrtSteps-1-step
  localparam int Sw = rme_pkg::SumWidth;
  logic [Sw-1:0] bit_w;
  logic [Sw+1:0] trial;
  rme_pkg::sqrt_t s_d;

  always_comb begin
    bit_w = '0;
    bit_w[2 * (rme_pkg::SqrtSteps - 1 - int'(step_i))] = 1'b1;
    // partial root sits above the trial bit, so it moves up by twice its position
    trial = {2'b00, s_i.rem} -
            ((({2'b00, Sw'(s_i.root)} << (2 * (rme_pkg::SqrtSteps - int'(step_i))))) |
             {2'b00, bit_w});
    s_d = s_i;
    if (!trial[Sw+1]) begin
      s_d.rem = trial[Sw-1:0];
      s_d.root = {s_i.root[rme_pkg::SqrtWidth-2:0], 1'b1};
    end else begin
      s_d.root = {s_i.root[rme_pkg::SqrtWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o <= 1'b0;
    else if (en_i) vld_o <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_o <= s_d;
      m_o <= m_i;
    end
  end
endmodule

@@ hdl/rme_cordic_cell.sv @@
module rme_cordic_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic [$clog2(rme_pkg::CordicStages)-1:0] stage_i,
  input  logic                                    vld_i,
  input  rme_pkg::lanes_t                         l_i,
  output logic                                    vld_o,
  output rme_pkg::lanes_t                         l_o
);
  rme_pkg::lanes_t l_d;

  function automatic rme_pkg::cord_t rot(rme_pkg::cord_t c, int i);
    rme_pkg::cord_t r;
    logic signed [rme_pkg::CordWidth-1:0] xs;
    logic signed [rme_pkg::CordWidth-1:0] ys;
    logic signed [rme_pkg::AngWidth-1:0] t;
    xs = c.x >>> i;
    ys = c.y >>> i;
    t = rme_pkg::AngWidth'(rme_pkg::AtanTab[i]);
    r = c;
    if (c.y >= 0) begin
      r.x = c.x + ys; r.y = c.y - xs; r.ang = c.ang + t;
    end else begin
      r.x = c.x - ys; r.y = c.y + xs; r.ang = c.ang - t;
    end
    return r;
  endfunction

  always_comb begin
    l_d.sing = l_i.sing;
    l_d.cx = rot(l_i.cx, int'(stage_i));
    l_d.cy = rot(l_i.cy, int'(stage_i));
    l_d.cz = rot(l_i.cz, int'(stage_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_o <= 1'b0;
    else if (en_i) vld_o <= vld_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) l_o <= l_d;
  end
endmodule

@@ hdl/rotation_matrix_to_euler.sv @@
// Matrix to XYZ Euler angles. One matrix enters per clock unless stalled;
// stages: squares register, 25 sqrt cells (one digit each), branch and
// CORDIC load register, 20 CORDIC cells (a rotation each), output register.
// Every cell shifts together while the output register is free or being
// taken, so a stall on m_axis holds the whole chain. Output tdata packs
// angle_x, angle_y, angle_z (23 bits each); tuser carries singular.
module rotation_matrix_to_euler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rme_pkg::ThrWidth-1:0]        cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // col0_row0, col1_row0, col2_row0, col2_row1, col2_row2, col1_row2, col1_row1
  input  logic [7*rme_pkg::DataWidth-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // angle_x, angle_y, angle_z, then 3 zero bits
  output logic [71:0]                         m_axis_tdata,
  // singular
  output logic                                m_axis_tuser
);
  localparam int Dw = rme_pkg::DataWidth;
  localparam int Ns = rme_pkg::SqrtSteps;
  localparam int Nc = rme_pkg::CordicStages;
  localparam int Ow = rme_pkg::OutWidth;

  logic [rme_pkg::ThrWidth-1:0] thr_q;
  logic en;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= rme_pkg::ThrReset;
    else if (cfg_valid_i) thr_q <= cfg_data_i;
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // squares stage
  rme_pkg::mat_t in_m;
  rme_pkg::mat_t sq_m_q;
  rme_pkg::sqrt_t sq_s_q;
  logic sq_v_q;
  logic signed [2*Dw-1:0] p0, p1;
  always_comb begin
    in_m.m00 = s_axis_tdata[0*Dw +: Dw];
    in_m.m10 = s_axis_tdata[1*Dw +: Dw];
    in_m.m20 = s_axis_tdata[2*Dw +: Dw];
    in_m.m21 = s_axis_tdata[3*Dw +: Dw];
    in_m.m22 = s_axis_tdata[4*Dw +: Dw];
    in_m.m12 = s_axis_tdata[5*Dw +: Dw];
    in_m.m11 = s_axis_tdata[6*Dw +: Dw];
    p0 = in_m.m00 * in_m.m00;
    p1 = in_m.m10 * in_m.m10;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sq_v_q <= 1'b0;
    else if (en) sq_v_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_m_q <= in_m;
      sq_s_q.rem <= {1'b0, p0} + {1'b0, p1};
      sq_s_q.root <= '0;
    end
  end

  // sqrt chain
  logic           sv [Ns+1];
  rme_pkg::sqrt_t ss [Ns+1];
  rme_pkg::mat_t  sm [Ns+1];
  assign sv[0] = sq_v_q;
  assign ss[0] = sq_s_q;
  assign sm[0] = sq_m_q;
  for (genvar g = 0; g < Ns; g++) begin : g_sqrt
    rme_sqrt_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .step_i($clog2(Ns)'(g)),
      .vld_i(sv[g]), .s_i(ss[g]), .m_i(sm[g]),
      .vld_o(sv[g+1]), .s_o(ss[g+1]), .m_o(sm[g+1]));
  end

  // branch select and CORDIC load
  rme_pkg::lanes_t ld_d;
  rme_pkg::lanes_t cl [Nc+1];
  logic            cv [Nc+1];
  logic            ld_v_q;
  rme_pkg::lanes_t ld_q;
  always_comb begin
    rme_pkg::mat_t m;
    logic signed [Dw:0] syx;
    m = sm[Ns];
    syx = {1'b0, ss[Ns].root[Dw-1:0]};
    ld_d.sing = ss[Ns].root < rme_pkg::SqrtWidth'(thr_q);
    // negating the most negative element wraps here; fixed up below
    ld_d.cy = rme_pkg::cord_init(-m.m20, syx);
    if (ss[Ns].root < rme_pkg::SqrtWidth'(thr_q)) begin
      ld_d.cx = rme_pkg::cord_init(-m.m12, (Dw+1)'(m.m11));
      ld_d.cz = rme_pkg::cord_init('0, '0);
    end else begin
      ld_d.cx = rme_pkg::cord_init(m.m21, (Dw+1)'(m.m22));
      ld_d.cz = rme_pkg::cord_init(m.m10, (Dw+1)'(m.m00));
    end
    // -most-negative handled below
    if (m.m20 == {1'b1, {(Dw-1){1'b0}}}) begin
      ld_d.cy.y = -(rme_pkg::CordWidth'(m.m20) <<< 8);
      ld_d.cy.zero = 1'b0;
    end
    if (ss[Ns].root < rme_pkg::SqrtWidth'(thr_q) &&
        m.m12 == {1'b1, {(Dw-1){1'b0}}}) begin
      ld_d.cx = rme_pkg::cord_init('0, (Dw+1)'(m.m11));
      if (m.m11 < 0) begin
        ld_d.cx.ang = rme_pkg::PiQ30;
        ld_d.cx.y = rme_pkg::CordWidth'(m.m12) <<< 8;
      end else begin
        ld_d.cx.y = -(rme_pkg::CordWidth'(m.m12) <<< 8);
      end
      ld_d.cx.zero = 1'b0;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ld_v_q <= 1'b0;
    else if (en) ld_v_q <= sv[Ns];
  end
  always_ff @(posedge clk_i) begin
    if (en) ld_q <= ld_d;
  end

  assign cv[0] = ld_v_q;
  assign cl[0] = ld_q;
  for (genvar g = 0; g < Nc; g++) begin : g_cord
    rme_cordic_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .stage_i($clog2(Nc)'(g)),
      .vld_i(cv[g]), .l_i(cl[g]),
      .vld_o(cv[g+1]), .l_o(cl[g+1]));
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= cv[Nc];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {3'b000,
                       cl[Nc].sing ? {Ow{1'b0}} : rme_pkg::ang_out(cl[Nc].cz),
                       rme_pkg::ang_out(cl[Nc].cy),
                       rme_pkg::ang_out(cl[Nc].cx)};
      m_axis_tuser <= cl[Nc].sing;
    end
  end

  // a stalled result must not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed under stall");
  // singular results carry a zero z angle
  a_zsing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3*Ow-1:2*Ow] == '0)
    else $error("z not zero when singular");
  // pad bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[71:3*Ow] == '0)
    else $error("pad bits set");
endmodule
